// ----- rtl/sibd_pkg.sv -----
package sibd_pkg;

    localparam int POS_BITS = 24;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_IMAGE = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;
    localparam logic [1:0] MODE_TIMER = 2'd3;

    localparam logic [1:0] REG_IMAGE_LENGTH = 2'd0;
    localparam logic [1:0] REG_FIRST_WORDS  = 2'd1;

    localparam logic [4:0] P_IDLE  = 5'd0;
    localparam logic [4:0] P_PING  = 5'd1;
    localparam logic [4:0] P_DATA  = 5'd2;
    localparam logic [4:0] P_MID   = 5'd3;
    localparam logic [4:0] P_BLK   = 5'd4;
    localparam logic [4:0] P_HDRB  = 5'd5;
    localparam logic [4:0] P_THDR  = 5'd6;
    localparam logic [4:0] P_TLEN  = 5'd7;
    localparam logic [4:0] P_TCMD  = 5'd8;
    localparam logic [4:0] P_TSTAT = 5'd9;
    localparam logic [4:0] P_TDATA = 5'd10;
    localparam logic [4:0] P_TCSUM = 5'd11;
    localparam logic [4:0] P_TFOOT = 5'd12;
    localparam logic [4:0] P_DONE  = 5'd16;

    localparam logic [7:0]  ACK_BYTE   = 8'h2d;
    localparam logic [15:0] HDR_MAGIC  = 16'h1be4;
    localparam logic [15:0] FOOT_MAGIC = 16'he41b;
    localparam logic [15:0] STATUS_OK  = 16'h1000;

    localparam logic [1:0] TMO_NONE = 2'd0;
    localparam logic [1:0] TMO_100  = 2'd1;
    localparam logic [1:0] TMO_300  = 2'd2;
    localparam logic [1:0] TMO_1000 = 2'd3;

    localparam logic [3:0] ERR_OK     = 4'd0;
    localparam logic [3:0] ERR_PING   = 4'd1;
    localparam logic [3:0] ERR_MID    = 4'd2;
    localparam logic [3:0] ERR_BLK    = 4'd3;
    localparam logic [3:0] ERR_HDR    = 4'd4;
    localparam logic [3:0] ERR_LEN    = 4'd5;
    localparam logic [3:0] ERR_CMD    = 4'd6;
    localparam logic [3:0] ERR_STAT   = 4'd7;
    localparam logic [3:0] ERR_DATA   = 4'd8;
    localparam logic [3:0] ERR_CSUM   = 4'd9;
    localparam logic [3:0] ERR_FOOT   = 4'd10;
    localparam logic [3:0] ERR_STATUS = 4'd11;

    localparam int QDEPTH = 4;
    localparam int QBITS  = 2;

    // classified event handed from front to back
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } event_t;

    // one result item
    typedef struct packed {
        logic                tx_valid;
        logic [7:0]          tx_byte;
        logic                flush_rx;
        logic [1:0]          wait_for;
        logic [1:0]          timeout_code;
        logic [POS_BITS-1:0] progress;
        logic                done_res;
        logic [3:0]          error_code;
        logic                last;
    } result_t;

    function automatic logic [7:0] ping_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0: b = 8'he4;
            4'd1: b = 8'h1b;
            4'd5: b = 8'h01;
            4'd6: b = 8'h01;
            4'd8: b = 8'h1b;
            4'd9: b = 8'he4;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/sibd_front.sv -----
module sibd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            mode,
    input  logic [7:0]            data_byte,
    output logic                  ev_valid,
    output sibd_pkg::event_t      ev,
    input  logic                  ev_take
);
    import sibd_pkg::*;

    event_t q_reg [QDEPTH];
    logic [QBITS-1:0] wr_reg, rd_reg;
    logic [QBITS:0]   cnt_reg;
    logic             do_push;

    assign full     = (cnt_reg == (QBITS+1)'(QDEPTH));
    assign do_push  = push && !full;
    assign ev_valid = (cnt_reg != '0);
    assign ev       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= '{mode: mode, data_byte: data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (ev_take)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QBITS+1)'(do_push) - (QBITS+1)'(ev_take);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) ev_take |-> ev_valid)
        else $error("event taken from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= (QBITS+1)'(QDEPTH))
        else $error("event queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !ev_take) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("event count lost a push");

endmodule

// ----- rtl/sibd_back.sv -----
module sibd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ev_valid,
    input  sibd_pkg::event_t          ev,
    output logic                      ev_take,
    input  logic [23:0]               image_length,
    input  logic [15:0]               first_block_words,
    output logic                      empty,
    input  logic                      pop,
    output sibd_pkg::result_t         res
);
    import sibd_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [1:0] KIND_PING = 2'd1;
    localparam logic [1:0] KIND_FOOT = 2'd2;

    logic [4:0]          phase_reg, phase_next;
    logic [15:0]         sum_reg, sum_next;
    logic [16:0]         bcnt_reg, bcnt_next;
    logic [15:0]         bwords_reg, bwords_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [7:0]          lowb_reg, lowb_next;
    logic                half_reg, half_next;
    logic [2:0]          hidx_reg, hidx_next;
    logic [15:0]         tlen_reg, tlen_next;
    logic [14:0]         dleft_reg, dleft_next;
    logic [15:0]         stat_reg, stat_next;

    // ping replay / footer second item
    logic [3:0]          seq_reg, seq_next;
    logic                busy_reg, busy_next;
    logic [1:0]          kind_reg, kind_next;

    logic                out_v_reg, out_v_next;
    result_t             out_reg, out_next;

    logic                arm_flush;
    logic [1:0]          arm;
    logic                emit;
    logic                tx_v;
    logic [7:0]          tx_b;
    logic                is_last;
    logic [15:0]         word;
    logic                wvalid;
    logic [16:0]         bc1;
    logic [15:0]         dl_calc;
    logic                slot_free;

    assign slot_free = !out_v_reg || pop;
    assign empty     = !out_v_reg;
    assign res       = out_reg;

    function automatic logic [1:0] wanted(input logic [4:0] p);
        logic [1:0] w;
        if (p == P_IDLE || p >= P_DONE)
            w = 2'd0;
        else if (p == P_DATA || p == P_HDRB)
            w = 2'd1;
        else
            w = 2'd2;
        return w;
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        bcnt_next   = bcnt_reg;
        bwords_next = bwords_reg;
        pos_next    = pos_reg;
        lowb_next   = lowb_reg;
        half_next   = half_reg;
        hidx_next   = hidx_reg;
        tlen_next   = tlen_reg;
        dleft_next  = dleft_reg;
        stat_next   = stat_reg;
        seq_next    = seq_reg;
        busy_next   = busy_reg;
        kind_next   = kind_reg;
        out_v_next  = out_v_reg && !pop;
        out_next    = out_reg;
        arm_flush   = 1'b0;
        arm         = TMO_NONE;
        emit        = 1'b0;
        tx_v        = 1'b0;
        tx_b        = 8'h00;
        is_last     = 1'b1;
        ev_take     = 1'b0;
        word        = {ev.data_byte, lowb_reg};
        wvalid      = (ev.mode == MODE_RX);
        bc1         = bcnt_reg + 17'd1;
        dl_calc     = (tlen_reg > 16'd2) ? ((tlen_reg - 16'd2) >> 1) : 16'd0;

        if (slot_free && busy_reg)
        begin
            emit = 1'b1;
            if (kind_reg == KIND_PING)
            begin
                // continue ping packet; final byte closes the event
                tx_v    = 1'b1;
                tx_b    = ping_byte(seq_reg);
                is_last = (seq_reg == 4'd9);
                arm     = is_last ? TMO_300 : TMO_NONE;
                seq_next = seq_reg + 4'd1;
                busy_next = !is_last;
            end
            else
            begin
                tx_v      = 1'b1;
                tx_b      = ACK_BYTE;
                phase_next = P_DONE + ((stat_reg != STATUS_OK) ? 5'(ERR_STATUS) : 5'(ERR_OK));
                busy_next = 1'b0;
            end
        end
        else if (slot_free && ev_valid)
        begin
            ev_take = 1'b1;
            emit    = 1'b1;
            if (ev.mode == MODE_START)
            begin
                sum_next    = '0;
                bcnt_next   = '0;
                pos_next    = '0;
                lowb_next   = '0;
                half_next   = 1'b0;
                hidx_next   = '0;
                tlen_next   = '0;
                dleft_next  = '0;
                stat_next   = '0;
                bwords_next = first_block_words;
                phase_next  = P_PING;
                tx_v        = 1'b1;
                tx_b        = ping_byte(4'd0);
                is_last     = 1'b0;
                seq_next    = 4'd1;
                busy_next   = 1'b1;
                kind_next   = KIND_PING;
            end
            else if (phase_reg == P_PING)
            begin
                if (ev.mode == MODE_RX && ev.data_byte == ACK_BYTE)
                begin
                    bcnt_next = '0;
                    if (bwords_reg == 16'd0)
                    begin
                        phase_next = P_BLK;
                        half_next  = 1'b0;
                        arm        = TMO_100;
                        arm_flush  = 1'b1;
                    end
                    else
                    begin
                        phase_next = P_DATA;
                    end
                end
                else if (ev.mode[1])
                begin
                    phase_next = P_DONE + 5'(ERR_PING);
                end
            end
            else if (ev.mode == MODE_IMAGE)
            begin
                if (phase_reg == P_DATA || phase_reg == P_HDRB)
                begin
                    tx_v = 1'b1;
                    tx_b = ev.data_byte;
                    if (pos_reg != POS_MAX)
                        pos_next = pos_reg + 1'b1;
                    sum_next = sum_reg + 16'(ev.data_byte);
                    if (phase_reg == P_DATA)
                    begin
                        bcnt_next = bc1;
                        if (bc1 >= {bwords_reg, 1'b0})
                        begin
                            phase_next = P_BLK;
                            half_next  = 1'b0;
                            arm        = TMO_100;
                            arm_flush  = 1'b1;
                        end
                        else if (bc1[7:0] == 8'd0)
                        begin
                            phase_next = P_MID;
                            half_next  = 1'b0;
                            arm        = TMO_100;
                            arm_flush  = 1'b1;
                        end
                    end
                    else
                    begin
                        if (hidx_reg == 3'd0)
                            bwords_next = {8'h00, ev.data_byte};
                        else if (hidx_reg == 3'd1)
                            bwords_next = {ev.data_byte, bwords_reg[7:0]};
                        hidx_next = hidx_reg + 3'd1;
                        if (hidx_reg == 3'd5)
                        begin
                            hidx_next = '0;
                            if (bwords_reg != 16'd0 && {8'h00, pos_next} <= {8'h00, image_length})
                            begin
                                bcnt_next = '0;
                                phase_next = P_DATA;
                            end
                            else
                            begin
                                phase_next = P_THDR;
                                half_next  = 1'b0;
                                arm        = TMO_1000;
                            end
                        end
                    end
                end
            end
            else if (phase_reg == P_IDLE || phase_reg >= P_DONE ||
                     phase_reg == P_DATA || phase_reg == P_HDRB)
            begin
                // unwanted event: one empty item
            end
            else if (ev.mode == MODE_RX && !half_reg)
            begin
                tx_v      = 1'b1;
                tx_b      = ACK_BYTE;
                lowb_next = ev.data_byte;
                half_next = 1'b1;
                arm       = (phase_reg == P_THDR) ? TMO_1000 : TMO_100;
            end
            else
            begin
                if (wvalid)
                begin
                    tx_v      = 1'b1;
                    tx_b      = ACK_BYTE;
                    half_next = 1'b0;
                end
                case (phase_reg)
                    P_MID:
                    begin
                        if (!wvalid) phase_next = P_DONE + 5'(ERR_MID);
                        else begin sum_next = word; phase_next = P_DATA; end
                    end
                    P_BLK:
                    begin
                        if (!wvalid || word != sum_reg) phase_next = P_DONE + 5'(ERR_BLK);
                        else begin phase_next = P_HDRB; hidx_next = '0; end
                    end
                    P_THDR:
                    begin
                        if (!wvalid || word != HDR_MAGIC) phase_next = P_DONE + 5'(ERR_HDR);
                        else begin phase_next = P_TLEN; half_next = 1'b0; arm = TMO_100; end
                    end
                    P_TLEN:
                    begin
                        if (!wvalid) phase_next = P_DONE + 5'(ERR_LEN);
                        else
                        begin
                            tlen_next = word; phase_next = P_TCMD;
                            half_next = 1'b0; arm = TMO_100;
                        end
                    end
                    P_TCMD:
                    begin
                        if (!wvalid) phase_next = P_DONE + 5'(ERR_CMD);
                        else begin phase_next = P_TSTAT; half_next = 1'b0; arm = TMO_100; end
                    end
                    P_TSTAT:
                    begin
                        if (!wvalid) phase_next = P_DONE + 5'(ERR_STAT);
                        else
                        begin
                            stat_next  = word;
                            dleft_next = dl_calc[14:0];
                            phase_next = (dl_calc[14:0] != 15'd0) ? P_TDATA : P_TCSUM;
                            half_next  = 1'b0;
                            arm        = TMO_100;
                        end
                    end
                    P_TDATA:
                    begin
                        if (!wvalid) phase_next = P_DONE + 5'(ERR_DATA);
                        else
                        begin
                            dleft_next = dleft_reg - 15'd1;
                            phase_next = (dleft_reg != 15'd1) ? P_TDATA : P_TCSUM;
                            half_next  = 1'b0;
                            arm        = TMO_100;
                        end
                    end
                    P_TCSUM:
                    begin
                        if (!wvalid) phase_next = P_DONE + 5'(ERR_CSUM);
                        else begin phase_next = P_TFOOT; half_next = 1'b0; arm = TMO_100; end
                    end
                    P_TFOOT:
                    begin
                        if (!wvalid || word != FOOT_MAGIC) phase_next = P_DONE + 5'(ERR_FOOT);
                        else
                        begin
                            // footer good: second ack follows as a separate item
                            is_last   = 1'b0;
                            busy_next = 1'b1;
                            kind_next = KIND_FOOT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (emit)
        begin
            out_v_next            = 1'b1;
            out_next.tx_valid     = tx_v;
            out_next.tx_byte      = tx_b;
            out_next.progress     = pos_next;
            out_next.last         = is_last;
            out_next.flush_rx     = is_last ? arm_flush : 1'b0;
            out_next.wait_for     = is_last ? wanted(phase_next) : 2'd0;
            out_next.timeout_code = is_last ? arm : TMO_NONE;
            out_next.done_res     = is_last && (phase_next >= P_DONE);
            out_next.error_code   = (is_last && phase_next >= P_DONE) ?
                                    phase_next[3:0] : ERR_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        sum_reg    <= sum_next;
        bcnt_reg   <= bcnt_next;
        bwords_reg <= bwords_next;
        lowb_reg   <= lowb_next;
        hidx_reg   <= hidx_next;
        tlen_reg   <= tlen_next;
        dleft_reg  <= dleft_next;
        stat_reg   <= stat_next;
        seq_reg    <= seq_next;
        kind_reg   <= kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            half_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            half_reg  <= half_next;
            busy_reg  <= busy_next;
            out_v_reg <= out_v_next;
            pos_reg   <= pos_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !ev_take)
        else $error("event taken during multi-item burst");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !pop) |=> $stable(out_reg))
        else $error("held result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_reg.done_res) |-> out_reg.last)
        else $error("done on non-final item");

endmodule

// ----- rtl/serial_image_block_download_core.sv -----
// Serial image block download, host side of a bootloader transfer.
// Input channel (push/full): one event per item, mode selects start, next
// image byte, received serial byte or timer expiry; data_byte carries the byte.
// Result channel (empty/pop): each event yields one or more result items; the
// final one has last set and carries wait_for, timeout_code, flush_rx and the
// done/error status. A start yields ten items (the ping), a good footer two.
// Configuration (cfg_we/cfg_index/cfg_data): the user must write image_length
// and first_block_words only while the block is idle; the block does not check.
// Timing: an accepted event waits in the event queue until the sequencer takes
// it and registers its first result; each further item of the same event is
// registered once the previous item is popped. A 4-entry event queue feeds the
// single result register of the sequencer; one item per cycle leaves when pop
// stays high.
// Reset clears the queue, the phase (idle) and the result valid flag;
// image_length resets to 0 and first_block_words to 11.
// When the receiver stalls, the result register holds and the event queue
// fills; full rises once four events wait.
module serial_image_block_download_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    mode,
    input  logic [7:0]                    data_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic                          tx_valid,
    output logic [7:0]                    tx_byte,
    output logic                          flush_rx,
    output logic [1:0]                    wait_for,
    output logic [1:0]                    timeout_code,
    output logic [sibd_pkg::POS_BITS-1:0] progress,
    output logic                          done_res,
    output logic [3:0]                    error_code,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [23:0]                   cfg_data
);
    import sibd_pkg::*;

    logic [23:0] image_length_reg;
    logic [15:0] first_words_reg;
    logic        ev_valid;
    logic        ev_take;
    event_t      ev;
    result_t     res;

    // hold configuration; only the two listed indexes take effect
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg <= '0;
            first_words_reg  <= 16'd11;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_LENGTH: image_length_reg <= cfg_data;
                REG_FIRST_WORDS:  first_words_reg  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    sibd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .data_byte (data_byte),
        .ev_valid  (ev_valid),
        .ev        (ev),
        .ev_take   (ev_take)
    );

    sibd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .ev_valid          (ev_valid),
        .ev                (ev),
        .ev_take           (ev_take),
        .image_length      (image_length_reg),
        .first_block_words (first_words_reg),
        .empty             (empty),
        .pop               (pop),
        .res               (res)
    );

    assign tx_valid     = res.tx_valid;
    assign tx_byte      = res.tx_byte;
    assign flush_rx     = res.flush_rx;
    assign wait_for     = res.wait_for;
    assign timeout_code = res.timeout_code;
    assign progress     = res.progress;
    assign done_res     = res.done_res;
    assign error_code   = res.error_code;
    assign last         = res.last;

endmodule
